### design/ritu_pkg.sv
// Shared widths, register indexes and limits for the radix integer-to-text unit.
// No dependencies; imported by every module of the block.
package ritu_pkg;

   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 5;
   localparam int CHAR_W = 8;
   localparam int SYMBOL_COUNT = 32;
   localparam int SYMBOL_REGS = 4;
   localparam int SYMBOL_REG_W = 64;
   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW = 6;
   localparam int TOTAL_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int DATA_W = 64;

   localparam int DEF_MAX_SYMBOLS = 32;
   localparam int DEF_VALUE_BITS = 64;

   localparam logic [CSR_IDX_W-1:0] REG_RADIX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SYM_0_7 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SYM_8_15 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SYM_16_23 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SYM_24_31 = 3'd4;

endpackage

### design/ritu_divider.sv
// Restoring divider that produces one quotient bit per cycle for the text unit.
// Depends on ritu_pkg for the divisor width.
module ritu_divider
   import ritu_pkg::*;
#(
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_W-1:0]    divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [RADIX_W-1:0]    remainder
);

   localparam int CNT_W = $clog2(VALUE_BITS);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [VALUE_BITS-1:0] quo_ff;
   logic [RADIX_W-1:0]    rem_ff;
   logic [RADIX_W:0]      trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[VALUE_BITS-2:0], fits};
         rem_ff <= fits ? RADIX_W'(trial - {1'b0, divisor}) : trial[RADIX_W-1:0];
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

### design/radix_integer_to_text_unit.sv
// Radix integer-to-text unit: checks the symbol table, divides repeatedly and emits digits.
// Depends on ritu_pkg and ritu_divider.
// Sequence: the table check steps through the symbols below the radix, then the shared
// divider yields one digit per division, then each character beat passes the fetch and emit
// states; an error gives one beat after the check. Items are taken one at a time.
// Reset: synchronous, active high; zeroes CSRs, counters and output valid; sequencer to idle.
module radix_integer_to_text_unit
   import ritu_pkg::*;
#(
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [63:0] value
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CHAR_W-1:0]    rsp_tdata,   // [7:0] character
   output logic                 rsp_tlast,
   output logic                 rsp_tuser    // [0] bad_base
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_ERROR = 3'd2;
   localparam logic [2:0] ST_DIV_START = 3'd3;
   localparam logic [2:0] ST_DIV_WAIT = 3'd4;
   localparam logic [2:0] ST_FETCH = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   localparam int SYM_FLAT_W = SYMBOL_REGS * SYMBOL_REG_W;

   logic [2:0]              state_ff, state_in;
   logic [RADIX_W-1:0]      radix_ff;
   logic [SYM_FLAT_W-1:0]   sym_flat_ff;
   logic [RADIX_W-1:0]      check_idx_ff, check_idx_in;
   logic [VALUE_BITS-1:0]   quotient_work_ff, quotient_work_in;
   logic [TOTAL_W-1:0]      digit_total_ff, digit_total_in;
   logic [STORE_AW-1:0]     emit_idx_ff, emit_idx_in;
   logic [DIGIT_W-1:0]      store_mem [STORE_DEPTH];
   logic [DIGIT_W-1:0]      rd_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_bad_ff, rsp_bad_in;
   logic                    out_free;
   logic [CHAR_W-1:0]       chk_sym;
   logic                    chk_bad;
   logic                    radix_bad;
   logic                    div_start;
   logic                    div_done;
   logic [VALUE_BITS-1:0]   div_quotient;
   logic [RADIX_W-1:0]      div_remainder;
   logic [TOTAL_W-1:0]      total_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
         sym_flat_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_RADIX: radix_ff <= csr_wdata[RADIX_W-1:0];
            REG_SYM_0_7: sym_flat_ff[0*SYMBOL_REG_W +: SYMBOL_REG_W] <= csr_wdata;
            REG_SYM_8_15: sym_flat_ff[1*SYMBOL_REG_W +: SYMBOL_REG_W] <= csr_wdata;
            REG_SYM_16_23: sym_flat_ff[2*SYMBOL_REG_W +: SYMBOL_REG_W] <= csr_wdata;
            REG_SYM_24_31: sym_flat_ff[3*SYMBOL_REG_W +: SYMBOL_REG_W] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign radix_bad = (radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_SYMBOLS));

   always_comb begin
      chk_sym = '0;
      if (check_idx_ff < RADIX_W'(SYMBOL_COUNT)) begin
         chk_sym = sym_flat_ff[{check_idx_ff[DIGIT_W-1:0], 3'b000} +: CHAR_W];
      end
      chk_bad = (chk_sym == '0);
      for (int j = 0; j < SYMBOL_COUNT; j++) begin
         if ((RADIX_W'(j) > check_idx_ff) && (RADIX_W'(j) < radix_ff)
             && (sym_flat_ff[j*CHAR_W +: CHAR_W] == chk_sym)) begin
            chk_bad = 1'b1;
         end
      end
   end

   ritu_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(quotient_work_ff),
      .divisor(radix_ff),
      .done(div_done),
      .quotient(div_quotient),
      .remainder(div_remainder)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign total_next = digit_total_ff + 1'b1;
   assign div_start = (state_ff == ST_DIV_START);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      check_idx_in = check_idx_ff;
      quotient_work_in = quotient_work_ff;
      digit_total_in = digit_total_ff;
      emit_idx_in = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in = rsp_bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               check_idx_in = '0;
               quotient_work_in = req_tdata[VALUE_BITS-1:0];
               digit_total_in = '0;
               state_in = radix_bad ? ST_ERROR : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (chk_bad) begin
               state_in = ST_ERROR;
            end else if (check_idx_ff == radix_ff - 1'b1) begin
               state_in = ST_DIV_START;
            end else begin
               check_idx_in = check_idx_ff + 1'b1;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = '0;
               rsp_last_in = 1'b1;
               rsp_bad_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               quotient_work_in = div_quotient;
               digit_total_in = total_next;
               if ((div_quotient != '0) && (total_next < TOTAL_W'(STORE_DEPTH))) begin
                  state_in = ST_DIV_START;
               end else begin
                  emit_idx_in = digit_total_ff[STORE_AW-1:0];
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in = sym_flat_ff[{rd_data_ff, 3'b000} +: CHAR_W];
               rsp_last_in = (emit_idx_ff == '0);
               rsp_bad_in = 1'b0;
               if (emit_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff - 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         check_idx_ff <= '0;
         quotient_work_ff <= '0;
         digit_total_ff <= '0;
         emit_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         check_idx_ff <= check_idx_in;
         quotient_work_ff <= quotient_work_in;
         digit_total_ff <= digit_total_in;
         emit_idx_ff <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         store_mem[digit_total_ff[STORE_AW-1:0]] <= div_remainder[DIGIT_W-1:0];
      end
      rd_data_ff <= store_mem[emit_idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_char_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_bad_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for radix_integer_to_text_unit: converts values under many symbol
// tables and checks every character beat against a predictor kept in step with the registers.
// Depends on ritu_pkg and the design files of the unit.
module tb_top;
   import ritu_pkg::*;

   localparam int MAX_SYMBOLS = DEF_MAX_SYMBOLS;
   localparam int VALUE_BITS = DEF_VALUE_BITS;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_PHASES = 7;
   localparam int ITEMS_PER_PHASE = 17;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_digit;
      logic              bad_base;
   } text_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wdata = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CHAR_W-1:0]    rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;

   radix_integer_to_text_unit #(
      .MAX_SYMBOLS(MAX_SYMBOLS),
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   logic [RADIX_W-1:0]      base_reg = '0;
   logic [SYMBOL_REG_W-1:0] glyph_regs [SYMBOL_REGS] = '{default: '0};
   logic [CHAR_W-1:0]       glyphs [SYMBOL_COUNT];

   text_beat_type text_expected [$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  beats_checked = 0;
   int  settings_used = 0;
   bit  idle_on = 1'b1;
   int  stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CHAR_W-1:0] glyph_of(input int d);
      if (d >= SYMBOL_REGS * 8) return '0;
      return glyph_regs[d / 8][(d % 8) * 8 +: 8];
   endfunction

   function automatic bit base_usable();
      int i;
      int j;
      logic [CHAR_W-1:0] g;
      if (base_reg < 2 || base_reg > MAX_SYMBOLS) return 1'b0;
      for (i = 0; i < base_reg; i++) begin
         g = glyph_of(i);
         if (g == '0) return 1'b0;
         for (j = i + 1; j < base_reg; j++)
            if (glyph_of(j) == g) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void predict_text(input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0]  quo;
      logic [DIGIT_W-1:0] digits [STORE_DEPTH];
      int n;
      int k;
      text_beat_type b;
      if (!base_usable()) begin
         b = '{character: '0, last_digit: 1'b1, bad_base: 1'b1};
         text_expected.push_back(b);
         return;
      end
      quo = (VALUE_BITS >= DATA_W) ? value : (value & ((64'd1 << VALUE_BITS) - 64'd1));
      n = 0;
      do begin
         digits[n] = DIGIT_W'(quo % base_reg);
         quo = quo / base_reg;
         n++;
      end while (quo != '0 && n < STORE_DEPTH);
      for (k = 0; k < n; k++) begin
         b.character = glyph_of(digits[n - 1 - k]);
         b.last_digit = (k == n - 1);
         b.bad_base = 1'b0;
         text_expected.push_back(b);
      end
   endfunction

   function automatic void note_failure(input string why, input text_beat_type want,
                                        input text_beat_type got);
      if (mismatches < MAX_REPORTS)
         $display("%0t: %s: expected char %h last %b bad %b, got char %h last %b bad %b",
                  $realtime, why, want.character, want.last_digit, want.bad_base,
                  got.character, got.last_digit, got.bad_base);
      mismatches++;
   endfunction

   // Results are checked before new expectations are queued, so a beat never meets its own item.
   always @(posedge clock) begin : check_beats
      text_beat_type got;
      text_beat_type want;
      if (rsp_tvalid && rsp_tready) begin
         got = '{character: rsp_tdata, last_digit: rsp_tlast, bad_base: rsp_tuser};
         beats_checked++;
         if (text_expected.size() == 0) begin
            note_failure("beat with nothing expected", 'x, got);
         end else begin
            want = text_expected.pop_front();
            if (got.character !== want.character || got.last_digit !== want.last_digit ||
                got.bad_base !== want.bad_base)
               note_failure("beat mismatch", want, got);
         end
      end
      if (req_tvalid && req_tready) begin
         predict_text(req_tdata);
         items_sent++;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_RADIX)
         base_reg = data[RADIX_W-1:0];
      else if (idx <= REG_SYM_24_31)
         glyph_regs[idx - REG_SYM_0_7] = data;
   endtask

   task automatic load_glyphs(input int radix);
      logic [SYMBOL_REG_W-1:0] word;
      int r;
      int i;
      write_reg(REG_RADIX, DATA_W'(radix));
      for (r = 0; r < SYMBOL_REGS; r++) begin
         word = '0;
         for (i = 0; i < 8; i++) word[i * 8 +: 8] = glyphs[r * 8 + i];
         write_reg(CSR_IDX_W'(REG_SYM_0_7 + r), word);
      end
      settings_used++;
   endtask

   task automatic ascii_glyphs();
      string digit_chars;
      int i;
      digit_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
      for (i = 0; i < SYMBOL_COUNT; i++) glyphs[i] = digit_chars[i];
   endtask

   task automatic shuffle_glyphs();
      logic [CHAR_W-1:0] pool [255];
      logic [CHAR_W-1:0] tmp;
      int i;
      int j;
      for (i = 0; i < 255; i++) pool[i] = CHAR_W'(i + 1);
      for (i = 0; i < SYMBOL_COUNT; i++) begin
         j = $urandom_range(i, 254);
         tmp = pool[i];
         pool[i] = pool[j];
         pool[j] = tmp;
         glyphs[i] = pool[i];
      end
   endtask

   task automatic send_value(input logic [DATA_W-1:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (text_expected.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_value('0);
      send_value('1);
      drain();
   endtask

   task automatic test_decimal();
      ascii_glyphs();
      load_glyphs(10);
      send_value(64'd0);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'd1234567890);
      send_value('1);
      drain();
   endtask

   task automatic test_binary();
      ascii_glyphs();
      load_glyphs(2);
      send_value(64'd1);
      send_value(64'h8000_0000_0000_0000);
      send_value('1);
      drain();
   endtask

   task automatic test_base32();
      ascii_glyphs();
      glyphs[30] = 8'h80;
      glyphs[31] = 8'hFF;
      load_glyphs(MAX_SYMBOLS);
      send_value(64'd31);
      send_value(64'd32);
      send_value('1);
      drain();
   endtask

   task automatic test_bad_tables();
      int i;
      ascii_glyphs();
      load_glyphs(1);
      send_value(64'd5);
      drain();
      load_glyphs(MAX_SYMBOLS + 1);
      send_value(64'd5);
      drain();
      // Only the low six bits of the radix register are kept; this leaves a radix of one.
      write_reg(REG_RADIX, 64'hFFFF_FFFF_FFFF_FFC1);
      send_value(64'd77);
      drain();
      glyphs[4] = '0;
      load_glyphs(10);
      send_value(64'd42);
      drain();
      ascii_glyphs();
      glyphs[31] = glyphs[0];
      load_glyphs(MAX_SYMBOLS);
      send_value(64'd42);
      drain();
      ascii_glyphs();
      glyphs[12] = glyphs[3];
      load_glyphs(12);
      send_value(64'd143);
      drain();
      for (i = REG_SYM_24_31 + 1; i < 2 ** CSR_IDX_W; i++) write_reg(CSR_IDX_W'(i), '1);
      send_value(64'hDEAD_BEEF);
      drain();
   endtask

   task automatic test_random_phases();
      int phase;
      int n;
      int radix;
      int j;
      logic [DATA_W-1:0] value;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase < RANDOM_PHASES - 1);
         shuffle_glyphs();
         radix = $urandom_range(2, MAX_SYMBOLS);
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: glyphs[$urandom_range(0, radix - 1)] = '0;
               1: begin
                  j = $urandom_range(1, radix - 1);
                  glyphs[j] = glyphs[$urandom_range(0, j - 1)];
               end
               2: radix = $urandom_range(0, 1);
               default: radix = $urandom_range(MAX_SYMBOLS + 1, 2 ** RADIX_W - 1);
            endcase
         end
         load_glyphs(radix);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            value = {$urandom, $urandom} >> $urandom_range(0, DATA_W - 1);
            send_value(value);
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) drain();
         end
         drain();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_decimal();
      test_binary();
      test_base32();
      test_bad_tables();
      test_random_phases();
      repeat (20) @(posedge clock);
      $display("Converted %0d values under %0d symbol tables, checking %0d character beats.",
               items_sent, settings_used, beats_checked);
      $display("Covered bases two to %0d, unusable tables and ignored register writes.",
               MAX_SYMBOLS);
      if (mismatches == 0 && text_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### radix_integer_to_text_unit.f
design/ritu_pkg.sv
design/ritu_divider.sv
design/radix_integer_to_text_unit.sv
tb/tb_top.sv
